>>> src/tnj_pkg.sv
// Types and constants shared by the tag network join and ranging block.
package tnj_pkg;

  typedef enum logic [2:0] {
    EV_BEACON     = 3'd0,
    EV_MISS       = 3'd1,
    EV_GRANT      = 3'd2,
    EV_GRANT_MISS = 3'd3,
    EV_DISCOVERED = 3'd4,
    EV_SWEPT      = 3'd5,
    EV_MOTION     = 3'd6,
    EV_OTHER      = 3'd7
  } event_e;

  typedef enum logic [3:0] {
    PH_SCAN     = 4'b0001,
    PH_JOINING  = 4'b0010,
    PH_DISCOVER = 4'b0100,
    PH_RANGING  = 4'b1000
  } phase_e;

  localparam logic [1:0] LS_SCAN     = 2'd0;
  localparam logic [1:0] LS_JOINING  = 2'd1;
  localparam logic [1:0] LS_DISCOVER = 2'd2;
  localparam logic [1:0] LS_RANGING  = 2'd3;

  typedef enum logic [2:0] {
    REG_PROTOCOL_VERSION   = 3'd0,
    REG_JOIN_RETRY_LIMIT   = 3'd1,
    REG_MISS_LIMIT         = 3'd2,
    REG_MIN_ANCHOR_COUNT   = 3'd3,
    REG_LEASE_LENGTH       = 3'd4,
    REG_SCHEDULE_GAP_LIMIT = 3'd5,
    REG_RANGE_EVERY_TABLE  = 3'd6,
    REG_BLINK_ENABLE       = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [1:0] TIER_IDLE = 2'd0;
  localparam logic [1:0] TIER_SLOW = 2'd1;
  localparam logic [1:0] TIER_FAST = 2'd2;

  localparam int unsigned ActJoin      = 0;
  localparam int unsigned ActDiscover  = 1;
  localparam int unsigned ActToScan    = 2;
  localparam int unsigned ActSleep     = 3;
  localparam int unsigned ActKeepalive = 4;
  localparam int unsigned ActSweep     = 5;
  localparam int unsigned ActBlink     = 6;
  localparam int unsigned ActAlert     = 7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  beacon_version;
    logic [31:0] beacon_frame;
    logic        scheduled;
    logic [7:0]  beacon_slot;
    logic [15:0] grant_address;
    logic [7:0]  grant_seat;
    logic [1:0]  grant_tier;
    logic [15:0] grant_lease;
    logic [7:0]  anchors_found;
    logic [1:0]  motion_tier;
    logic        alert_waiting;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  actions;
    logic [1:0]  link_state;
    logic [1:0]  active_tier;
    logic [7:0]  transmit_slot;
    logic [15:0] own_address;
    logic [7:0]  own_seat;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  protocol_version;
    logic [7:0]  join_retry_limit;
    logic [7:0]  miss_limit;
    logic [7:0]  min_anchor_count;
    logic [15:0] lease_length;
    logic [31:0] schedule_gap_limit;
    logic [23:0] range_every_table;
    logic        blink_enable;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  tier_now;
    logic [31:0] last_frame;
    logic [7:0]  missed_beacons;
    logic [7:0]  join_attempts;
    logic [15:0] address_held;
    logic [7:0]  seat_held;
    logic [15:0] lease_left;
    logic [31:0] last_scheduled_frame;
    logic [7:0]  anchor_count;
    logic [7:0]  slot_held;
    logic [7:0]  participations;
  } link_st_t;

endpackage

>>> src/tnj_core.sv
// Next-state and action logic for one event word.
module tnj_core import tnj_pkg::*; (
  input  cfg_t      cfg_i,
  input  link_st_t  st_i,
  input  in_word_t  word_i,
  output link_st_t  st_o,
  output out_word_t res_o
);

  logic [31:0] elapsed;
  logic [31:0] gap;
  logic [15:0] lease_aged;
  logic        ver_ok;
  logic [7:0]  miss_inc;
  logic [7:0]  join_inc;
  logic [7:0]  part_inc;
  logic [7:0]  div_raw;
  logic [7:0]  divisor;
  logic        gap_trip;
  logic        renew;
  logic [7:0]  act;
  logic [1:0]  ls_code;
  event_e      mode;

  assign mode       = event_e'(word_i.mode);
  assign ver_ok     = (word_i.beacon_version == cfg_i.protocol_version);
  assign elapsed    = word_i.beacon_frame - st_i.last_frame;
  assign lease_aged = ({16'd0, st_i.lease_left} > elapsed) ?
                      (st_i.lease_left - elapsed[15:0]) : 16'd0;
  assign gap        = word_i.beacon_frame - st_i.last_scheduled_frame;
  assign gap_trip   = !word_i.scheduled && (gap > cfg_i.schedule_gap_limit);
  assign renew      = (lease_aged <= {1'b0, cfg_i.lease_length[15:1]});
  assign miss_inc   = st_i.missed_beacons + 8'd1;
  assign join_inc   = st_i.join_attempts + 8'd1;
  assign part_inc   = st_i.participations + 8'd1;

  always_comb begin
    case (st_i.tier_now)
      TIER_IDLE: div_raw = cfg_i.range_every_table[7:0];
      TIER_SLOW: div_raw = cfg_i.range_every_table[15:8];
      default:   div_raw = cfg_i.range_every_table[23:16];
    endcase
    divisor = (div_raw == 8'd0) ? 8'd1 : div_raw;
  end

  always_comb begin
    st_o = st_i;
    act  = 8'd0;
    if (mode == EV_MOTION) begin
      st_o.tier_now = word_i.motion_tier;
    end else begin
      case (st_i.phase)
        PH_SCAN: begin
          if (mode == EV_BEACON && ver_ok) begin
            st_o.last_frame     = word_i.beacon_frame;
            st_o.missed_beacons = 8'd0;
            st_o.join_attempts  = 8'd0;
            st_o.phase          = PH_JOINING;
            act[ActJoin]        = 1'b1;
          end else begin
            act[ActSleep] = 1'b1;
          end
        end
        PH_JOINING: begin
          if (mode == EV_GRANT) begin
            st_o.address_held         = word_i.grant_address;
            st_o.seat_held            = word_i.grant_seat;
            st_o.tier_now             = word_i.grant_tier;
            st_o.lease_left           = word_i.grant_lease;
            st_o.missed_beacons       = 8'd0;
            st_o.last_scheduled_frame = st_i.last_frame;
            st_o.phase                = PH_DISCOVER;
            act[ActDiscover]          = 1'b1;
          end else if (mode == EV_GRANT_MISS) begin
            st_o.join_attempts = join_inc;
            if (join_inc >= cfg_i.join_retry_limit) begin
              st_o.phase = PH_SCAN;
            end else begin
              act[ActJoin] = 1'b1;
            end
          end else if (mode == EV_BEACON && ver_ok) begin
            st_o.missed_beacons = 8'd0;
            st_o.last_frame     = word_i.beacon_frame;
            act[ActJoin]        = 1'b1;
          end
        end
        PH_DISCOVER, PH_RANGING: begin
          if (mode == EV_MISS) begin
            if (miss_inc >= cfg_i.miss_limit) begin
              st_o.phase          = PH_SCAN;
              st_o.missed_beacons = 8'd0;
              act[ActToScan]      = 1'b1;
            end else begin
              st_o.missed_beacons = miss_inc;
            end
          end else if (mode == EV_DISCOVERED && st_i.phase == PH_DISCOVER) begin
            st_o.anchor_count = word_i.anchors_found;
            if (word_i.anchors_found >= cfg_i.min_anchor_count) begin
              st_o.phase = PH_RANGING;
            end else begin
              act[ActDiscover] = 1'b1;
            end
          end else if (mode == EV_SWEPT && st_i.phase == PH_RANGING) begin
            if (word_i.anchors_found < cfg_i.min_anchor_count) begin
              st_o.phase       = PH_DISCOVER;
              act[ActDiscover] = 1'b1;
            end
          end else if (mode == EV_BEACON) begin
            st_o.missed_beacons = 8'd0;
            st_o.last_frame     = word_i.beacon_frame;
            st_o.lease_left     = lease_aged;
            if (word_i.scheduled) begin
              st_o.slot_held            = word_i.beacon_slot;
              st_o.last_scheduled_frame = word_i.beacon_frame;
            end
            if (gap_trip) begin
              st_o.phase     = PH_SCAN;
              act[ActToScan] = 1'b1;
            end else begin
              if (renew) begin
                act[ActKeepalive] = 1'b1;
                st_o.lease_left   = cfg_i.lease_length;
              end
              if (!word_i.scheduled) begin
                act[ActSleep] = 1'b1;
              end else if (st_i.phase == PH_DISCOVER) begin
                act[ActDiscover] = 1'b1;
              end else if (part_inc >= divisor) begin
                st_o.participations = 8'd0;
                if (cfg_i.blink_enable) begin
                  act[ActBlink] = 1'b1;
                end else begin
                  act[ActSweep] = 1'b1;
                end
              end else begin
                st_o.participations = part_inc;
                act[ActSleep]       = 1'b1;
              end
            end
          end
        end
        default: begin
          st_o.phase = PH_SCAN;
        end
      endcase
    end
    if (word_i.alert_waiting &&
        (mode == EV_BEACON || (st_i.phase == PH_SCAN && mode == EV_MISS))) begin
      act[ActAlert] = 1'b1;
    end
  end

  always_comb begin
    case (st_o.phase)
      PH_SCAN:     ls_code = LS_SCAN;
      PH_JOINING:  ls_code = LS_JOINING;
      PH_DISCOVER: ls_code = LS_DISCOVER;
      PH_RANGING:  ls_code = LS_RANGING;
      default:     ls_code = LS_SCAN;
    endcase
  end

  assign res_o.actions       = act;
  assign res_o.link_state    = ls_code;
  assign res_o.active_tier   = st_o.tier_now;
  assign res_o.transmit_slot = st_o.slot_held;
  assign res_o.own_address   = st_o.address_held;
  assign res_o.own_seat      = st_o.seat_held;

endmodule

>>> src/tag_network_join_range_fsm.sv
// Top level of the tag-side network join, discovery and ranging controller.
// One event word gives one result word. An event is captured in an input
// register, decoded combinationally against the link state and written to
// the output register while the state updates, so a new event is taken
// every cycle unless the output stalls. The pipeline holds only when the
// output register is full and stalled.
// Configuration writes take effect on the next cycle and are expected only
// while no event is in flight.
module tag_network_join_range_fsm import tnj_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  in_word_t  in_q;
  logic      in_vld_q;
  out_word_t out_q;
  logic      out_vld_q;
  link_st_t  st_q;
  link_st_t  st_d;
  out_word_t res;
  cfg_t      cfg_q;
  logic      out_free;
  logic      fire;
  logic      take;
  reg_idx_e  idx;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign take       = in_valid_i && !in_stall_o;
  assign idx        = reg_idx_e'(cfg_idx_i);

  tnj_core u_core (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .word_i (in_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_data_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  // link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase                <= PH_SCAN;
      st_q.tier_now             <= TIER_FAST;
      st_q.last_frame           <= '0;
      st_q.missed_beacons       <= '0;
      st_q.join_attempts        <= '0;
      st_q.address_held         <= '0;
      st_q.seat_held            <= '0;
      st_q.lease_left           <= '0;
      st_q.last_scheduled_frame <= '0;
      st_q.anchor_count         <= '0;
      st_q.slot_held            <= '0;
      st_q.participations       <= '0;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_version   <= 8'd1;
      cfg_q.join_retry_limit   <= 8'd5;
      cfg_q.miss_limit         <= 8'd5;
      cfg_q.min_anchor_count   <= 8'd3;
      cfg_q.lease_length       <= 16'd50;
      cfg_q.schedule_gap_limit <= 32'd100;
      cfg_q.range_every_table  <= 24'h010101;
      cfg_q.blink_enable       <= 1'b0;
    end else if (cfg_we_i) begin
      case (idx)
        REG_PROTOCOL_VERSION:   cfg_q.protocol_version   <= cfg_wdata_i[7:0];
        REG_JOIN_RETRY_LIMIT:   cfg_q.join_retry_limit   <= cfg_wdata_i[7:0];
        REG_MISS_LIMIT:         cfg_q.miss_limit         <= cfg_wdata_i[7:0];
        REG_MIN_ANCHOR_COUNT:   cfg_q.min_anchor_count   <= cfg_wdata_i[7:0];
        REG_LEASE_LENGTH:       cfg_q.lease_length       <= cfg_wdata_i[15:0];
        REG_SCHEDULE_GAP_LIMIT: cfg_q.schedule_gap_limit <= cfg_wdata_i[31:0];
        REG_RANGE_EVERY_TABLE:  cfg_q.range_every_table  <= cfg_wdata_i[23:0];
        REG_BLINK_ENABLE:       cfg_q.blink_enable       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the tag network join and ranging block.
`timescale 1ns / 100ps

module tb_top;
  import tnj_pkg::*;

  localparam int StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic ev_valid = 1'b0;
  logic ev_stall;
  in_word_t ev_word = '0;
  logic rep_valid;
  logic rep_stall = 1'b0;
  out_word_t rep_word;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  in_word_t queued_events[$];
  out_word_t awaited_reports[$];
  int events_made = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  cfg_t link_cfg;
  logic [1:0] lk_phase;
  logic [1:0] lk_tier_now;
  logic [1:0] lk_tier_asked;
  logic [31:0] lk_last_frame;
  logic [31:0] lk_last_sched;
  logic [7:0] lk_missed;
  logic [7:0] lk_joins;
  logic [15:0] lk_address;
  logic [7:0] lk_seat;
  logic [15:0] lk_lease;
  logic [7:0] lk_anchors;
  logic [7:0] lk_slot;
  logic [7:0] lk_parts;

  tag_network_join_range_fsm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ev_valid),
    .in_stall_o  (ev_stall),
    .in_data_i   (ev_word),
    .out_valid_o (rep_valid),
    .out_stall_i (rep_stall),
    .out_data_o  (rep_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] count_missed_beacon();
    logic [7:0] act;
    act = '0;
    lk_missed = lk_missed + 8'd1;
    if (lk_missed >= link_cfg.miss_limit) begin
      lk_phase = LS_SCAN;
      lk_missed = '0;
      act[ActToScan] = 1'b1;
    end
    return act;
  endfunction

  function automatic logic [7:0] beacon_in_sync(in_word_t w, output logic done);
    logic [7:0] act;
    logic [31:0] elapsed;
    logic [31:0] unsched;
    act = '0;
    done = 1'b0;
    lk_missed = '0;
    elapsed = w.beacon_frame - lk_last_frame;
    if ({16'd0, lk_lease} > elapsed) lk_lease = lk_lease - elapsed[15:0];
    else lk_lease = '0;
    lk_last_frame = w.beacon_frame;
    unsched = w.beacon_frame - lk_last_sched;
    if (w.scheduled) begin
      lk_slot = w.beacon_slot;
      lk_last_sched = w.beacon_frame;
    end else if (unsched > link_cfg.schedule_gap_limit) begin
      lk_phase = LS_SCAN;
      done = 1'b1;
      act[ActToScan] = 1'b1;
      return act;
    end
    if (lk_lease <= (link_cfg.lease_length >> 1)) begin
      act[ActKeepalive] = 1'b1;
      lk_lease = link_cfg.lease_length;
    end
    if (!w.scheduled) begin
      done = 1'b1;
      act[ActSleep] = 1'b1;
    end
    return act;
  endfunction

  function automatic out_word_t step_link_fsm(in_word_t w);
    logic [1:0] prior;
    logic [7:0] act;
    logic done;
    logic [1:0] sel;
    logic [7:0] divisor;
    logic ver_ok;
    out_word_t r;
    prior = lk_phase;
    act = '0;
    done = 1'b0;
    ver_ok = (w.beacon_version == link_cfg.protocol_version);
    if (w.mode == EV_MOTION) begin
      lk_tier_asked = w.motion_tier;
      lk_tier_now = lk_tier_asked;
    end else begin
      case (lk_phase)
        LS_SCAN: begin
          if (w.mode == EV_BEACON && ver_ok) begin
            lk_last_frame = w.beacon_frame;
            lk_missed = '0;
            lk_joins = '0;
            lk_phase = LS_JOINING;
            act[ActJoin] = 1'b1;
          end else begin
            act[ActSleep] = 1'b1;
          end
        end
        LS_JOINING: begin
          if (w.mode == EV_GRANT) begin
            lk_address = w.grant_address;
            lk_seat = w.grant_seat;
            lk_tier_now = w.grant_tier;
            lk_lease = w.grant_lease;
            lk_missed = '0;
            lk_last_sched = lk_last_frame;
            lk_phase = LS_DISCOVER;
            act[ActDiscover] = 1'b1;
          end else if (w.mode == EV_GRANT_MISS) begin
            lk_joins = lk_joins + 8'd1;
            if (lk_joins >= link_cfg.join_retry_limit) lk_phase = LS_SCAN;
            else act[ActJoin] = 1'b1;
          end else if (w.mode == EV_BEACON && ver_ok) begin
            lk_missed = '0;
            lk_last_frame = w.beacon_frame;
            act[ActJoin] = 1'b1;
          end
        end
        LS_DISCOVER: begin
          if (w.mode == EV_DISCOVERED) begin
            lk_anchors = w.anchors_found;
            if (lk_anchors >= link_cfg.min_anchor_count) lk_phase = LS_RANGING;
            else act[ActDiscover] = 1'b1;
          end else if (w.mode == EV_MISS) begin
            act = count_missed_beacon();
          end else if (w.mode == EV_BEACON) begin
            act = beacon_in_sync(w, done);
            if (!done) act[ActDiscover] = 1'b1;
          end
        end
        default: begin
          if (w.mode == EV_MISS) begin
            act = count_missed_beacon();
          end else if (w.mode == EV_SWEPT) begin
            if (w.anchors_found < link_cfg.min_anchor_count) begin
              lk_phase = LS_DISCOVER;
              act[ActDiscover] = 1'b1;
            end
          end else if (w.mode == EV_BEACON) begin
            act = beacon_in_sync(w, done);
            if (!done) begin
              lk_parts = lk_parts + 8'd1;
              sel = (lk_tier_now > TIER_FAST) ? TIER_FAST : lk_tier_now;
              divisor = link_cfg.range_every_table[{sel, 3'b000} +: 8];
              if (divisor == 8'd0) divisor = 8'd1;
              if (lk_parts >= divisor) begin
                lk_parts = '0;
                if (link_cfg.blink_enable) act[ActBlink] = 1'b1;
                else act[ActSweep] = 1'b1;
              end else begin
                act[ActSleep] = 1'b1;
              end
            end
          end
        end
      endcase
    end
    if (w.alert_waiting && (w.mode == EV_BEACON || (prior == LS_SCAN && w.mode == EV_MISS)))
      act[ActAlert] = 1'b1;
    r.actions = act;
    r.link_state = lk_phase;
    r.active_tier = lk_tier_now;
    r.transmit_slot = lk_slot;
    r.own_address = lk_address;
    r.own_seat = lk_seat;
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", field, want, got);
      mismatches++;
    end
  endtask

  function automatic in_word_t make_event(logic [2:0] m);
    logic [127:0] raw;
    in_word_t w;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.mode = m;
    return w;
  endfunction

  task automatic enqueue(in_word_t w);
    queued_events.push_back(w);
    events_made++;
  endtask

  task automatic add_session(int beats);
    in_word_t w;
    logic [31:0] frame;
    frame = $urandom;
    w = make_event(EV_BEACON);
    w.beacon_version = link_cfg.protocol_version;
    w.beacon_frame = frame;
    enqueue(w);
    repeat ($urandom_range(2)) enqueue(make_event(EV_GRANT_MISS));
    enqueue(make_event(EV_GRANT));
    if ($urandom_range(3) == 0) enqueue(make_event(EV_DISCOVERED));
    w = make_event(EV_DISCOVERED);
    w.anchors_found = 8'($urandom_range(255, link_cfg.min_anchor_count));
    enqueue(w);
    repeat (beats) begin
      case ($urandom_range(19))
        0, 1: enqueue(make_event(EV_MISS));
        2: enqueue(make_event(EV_SWEPT));
        3: enqueue(make_event(EV_MOTION));
        4: enqueue(make_event(3'($urandom_range(7))));
        default: begin
          if ($urandom_range(24) == 0) frame = frame - $urandom_range(1, 5000);
          else frame = frame + $urandom_range(1, 3);
          w = make_event(EV_BEACON);
          w.beacon_version = link_cfg.protocol_version;
          w.beacon_frame = frame;
          w.scheduled = ($urandom_range(9) != 0);
          enqueue(w);
        end
      endcase
    end
  endtask

  task automatic fill_phase(int target);
    int goal;
    goal = events_made + target;
    while (events_made < goal) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 6)) enqueue(make_event(3'($urandom_range(7))));
      end else begin
        add_session($urandom_range(2, 24));
      end
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_PROTOCOL_VERSION:   link_cfg.protocol_version = v[7:0];
      REG_JOIN_RETRY_LIMIT:   link_cfg.join_retry_limit = v[7:0];
      REG_MISS_LIMIT:         link_cfg.miss_limit = v[7:0];
      REG_MIN_ANCHOR_COUNT:   link_cfg.min_anchor_count = v[7:0];
      REG_LEASE_LENGTH:       link_cfg.lease_length = v[15:0];
      REG_SCHEDULE_GAP_LIMIT: link_cfg.schedule_gap_limit = v;
      REG_RANGE_EVERY_TABLE:  link_cfg.range_every_table = v[23:0];
      default:                link_cfg.blink_enable = v[0];
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [7:0] ver, logic [7:0] retry, logic [7:0] miss,
                           logic [7:0] anchors, logic [15:0] lease, logic [31:0] gap,
                           logic [23:0] table_val, logic blink);
    write_reg(REG_PROTOCOL_VERSION, {24'd0, ver});
    write_reg(REG_JOIN_RETRY_LIMIT, {24'd0, retry});
    write_reg(REG_MISS_LIMIT, {24'd0, miss});
    write_reg(REG_MIN_ANCHOR_COUNT, {24'd0, anchors});
    write_reg(REG_LEASE_LENGTH, {16'd0, lease});
    write_reg(REG_SCHEDULE_GAP_LIMIT, gap);
    write_reg(REG_RANGE_EVERY_TABLE, {8'd0, table_val});
    write_reg(REG_BLINK_ENABLE, {31'd0, blink});
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (queued_events.size() != 0 || ev_valid || awaited_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // event driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid <= 1'b0;
      ev_word <= '0;
    end else begin
      if (ev_valid && !ev_stall) awaited_reports.push_back(step_link_fsm(ev_word));
      if (!ev_valid || !ev_stall) begin
        if (queued_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev_word <= queued_events.pop_front();
          ev_valid <= 1'b1;
        end else begin
          ev_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      rep_stall <= 1'b0;
    end else begin
      if (rep_valid && !rep_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("result word with none expected: %0h", rep_word);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("actions", 32'(want.actions), 32'(rep_word.actions));
          check_field("link_state", 32'(want.link_state), 32'(rep_word.link_state));
          check_field("active_tier", 32'(want.active_tier), 32'(rep_word.active_tier));
          check_field("transmit_slot", 32'(want.transmit_slot), 32'(rep_word.transmit_slot));
          check_field("own_address", 32'(want.own_address), 32'(rep_word.own_address));
          check_field("own_seat", 32'(want.own_seat), 32'(rep_word.own_seat));
        end
      end
      rep_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((ev_valid && !ev_stall) || (rep_valid && !rep_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_word_t w;
    link_cfg.protocol_version = 8'd1;
    link_cfg.join_retry_limit = 8'd5;
    link_cfg.miss_limit = 8'd5;
    link_cfg.min_anchor_count = 8'd3;
    link_cfg.lease_length = 16'd50;
    link_cfg.schedule_gap_limit = 32'd100;
    link_cfg.range_every_table = 24'h010101;
    link_cfg.blink_enable = 1'b0;
    lk_phase = LS_SCAN;
    lk_tier_now = TIER_FAST;
    lk_tier_asked = TIER_FAST;
    lk_last_frame = '0;
    lk_last_sched = '0;
    lk_missed = '0;
    lk_joins = '0;
    lk_address = '0;
    lk_seat = '0;
    lk_lease = '0;
    lk_anchors = '0;
    lk_slot = '0;
    lk_parts = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    w = make_event(EV_MOTION); w.motion_tier = 2'd3; enqueue(w);
    w = make_event(EV_MISS); w.alert_waiting = 1'b1; enqueue(w);
    w = make_event(EV_BEACON); w.beacon_version = 8'd0; w.alert_waiting = 1'b1; enqueue(w);
    enqueue(make_event(EV_OTHER));
    w = make_event(EV_BEACON); w.beacon_version = 8'd1; w.beacon_frame = 32'hFFFF_FFF0;
    enqueue(w);
    enqueue(make_event(EV_GRANT_MISS));
    enqueue(make_event(EV_SWEPT));
    w = make_event(EV_BEACON); w.beacon_version = 8'd1; w.beacon_frame = 32'hFFFF_FFF8;
    enqueue(w);
    w = make_event(EV_GRANT);
    w.grant_address = 16'hFFFF; w.grant_seat = 8'hFF; w.grant_tier = 2'd3;
    w.grant_lease = 16'hFFFF;
    enqueue(w);
    w = make_event(EV_DISCOVERED); w.anchors_found = 8'd2; enqueue(w);
    enqueue(make_event(EV_MISS));
    w = make_event(EV_BEACON); w.beacon_frame = 32'd4; w.scheduled = 1'b1;
    w.beacon_slot = 8'hFF;
    enqueue(w);
    w = make_event(EV_DISCOVERED); w.anchors_found = 8'hFF; enqueue(w);
    w = make_event(EV_BEACON); w.beacon_frame = 32'd6; w.scheduled = 1'b1; enqueue(w);
    w = make_event(EV_BEACON); w.beacon_frame = 32'd2; w.scheduled = 1'b1; enqueue(w);
    w = make_event(EV_MOTION); w.motion_tier = 2'd0; enqueue(w);
    w = make_event(EV_BEACON); w.beacon_frame = 32'd3; w.scheduled = 1'b0; enqueue(w);
    w = make_event(EV_SWEPT); w.anchors_found = 8'd0; enqueue(w);
    w = make_event(EV_DISCOVERED); w.anchors_found = 8'd3; enqueue(w);
    enqueue(make_event(EV_OTHER));
    w = make_event(EV_BEACON); w.beacon_frame = 32'd200; w.scheduled = 1'b0; enqueue(w);
    w = make_event(EV_MISS); w.alert_waiting = 1'b1; enqueue(w);
    fill_phase(60);
    wait_quiet();

    write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1);
    send_idle_pct = 81;
    stall_pct = 0;
    fill_phase(80);
    wait_quiet();

    write_all(8'h00, 8'd1, 8'd1, 8'd1, 16'd2, 32'd0, 24'h000000, 1'b0);
    send_idle_pct = 0;
    stall_pct = 81;
    fill_phase(80);
    wait_quiet();

    write_all(8'($urandom), 8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
              8'($urandom_range(1, 4)), 16'($urandom_range(2, 200)),
              32'($urandom_range(0, 20)),
              {8'($urandom_range(4)), 8'($urandom_range(4)), 8'($urandom_range(4))},
              1'($urandom_range(1)));
    send_idle_pct = 6;
    stall_pct = 6;
    fill_phase(80);
    wait_quiet();

    // zero retry and miss limits trip on the first grant miss or missed beacon
    write_all(8'($urandom), 8'd0, 8'd0, 8'($urandom_range(1, 4)),
              16'($urandom_range(2, 65535)), 32'd500, 24'h030201, 1'b1);
    send_idle_pct = 0;
    stall_pct = 0;
    fill_phase(80);
    wait_quiet();

    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
